// ----- sv/uae_pkg.sv -----
`default_nettype none
package uae_pkg;

    localparam int WORD_W   = 32;
    localparam int SYM_W    = 16;
    localparam int SIZE_W   = 17;
    localparam int CNT_W    = 6;
    localparam int DIV_ITERS    = WORD_W;
    localparam int RENORM_STEPS = WORD_W;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [WORD_W-1:0] TOP_BIT    = WORD_W'(1) << (WORD_W - 1);
    localparam logic [WORD_W-1:0] SECOND_BIT = WORD_W'(1) << (WORD_W - 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_RENORM,
        ST_FLUSH,
        ST_LAST
    } state_t;

    typedef enum logic [1:0] {
        DEC_ZERO,
        DEC_ONE,
        DEC_E3,
        DEC_STOP
    } dec_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic update;
        logic emit;
        logic e3;
        logic flush;
        logic final_push;
    } cmd_t;

    typedef struct packed {
        dec_t dec;
        logic fin;
        logic held_valid;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- sv/uae_ctrl.sv -----
`default_nettype none
module uae_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire uae_pkg::status_t status,
    output uae_pkg::cmd_t        cmd
);
    import uae_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = ST_RENORM;
            end
            ST_RENORM:
            begin
                if (cnt_reg == CNT_W'(RENORM_STEPS) || status.dec == DEC_STOP)
                    state_next = status.fin ? ST_FLUSH : ST_LAST;
                else if (status.dec == DEC_E3)
                begin
                    cmd.e3   = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // a new run displaces the held one, so the output slot must be free
                else if (!status.held_valid || status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!status.held_valid || status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (!status.held_valid)
                    state_next = ST_IDLE;
                else if (status.out_free)
                begin
                    cmd.final_push = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/uae_dpath.sv -----
`default_nettype none
module uae_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [uae_pkg::SIZE_W-1:0] cfg_wdata,
    input  wire logic [uae_pkg::SYM_W-1:0]  in_symbol,
    input  wire logic                       in_finish,
    input  wire uae_pkg::cmd_t              cmd,
    output uae_pkg::status_t                status,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            out_lead,
    output logic [uae_pkg::WORD_W-1:0]      out_follow,
    output logic                            out_last
);
    import uae_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [WORD_W-1:0] low_reg, high_reg, pend_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [SIZE_W-1:0] sym_reg;
    logic              fin_reg;
    logic [WORD_W-1:0] prod_reg;
    logic              held_valid_reg, held_bit_reg;
    logic [WORD_W-1:0] held_follow_reg;
    logic              out_valid_reg, out_lead_reg, out_last_reg;
    logic [WORD_W-1:0] out_follow_reg;

    logic [SIZE_W-1:0]        div_eff;
    logic [SIZE_W-1:0]        sym_ext;
    logic [SIZE_W:0]          trial;
    logic                     trial_ge;
    logic [WORD_W+SIZE_W-1:0] mul_full;
    logic [WORD_W-1:0]        low_sum;
    logic [WORD_W-1:0]        pend_sat;
    logic                     out_free;
    logic                     push_mid;
    dec_t                     dec;

    // size zero divides as size one
    assign div_eff  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign sym_ext  = {1'b0, in_symbol};
    assign trial    = {rem_reg, quo_reg[WORD_W-1]};
    assign trial_ge = trial >= {1'b0, div_eff};
    assign mul_full = {{SIZE_W{1'b0}}, quo_reg} * {{WORD_W{1'b0}}, sym_reg};
    assign low_sum  = low_reg + prod_reg;
    assign pend_sat = (pend_reg == '1) ? pend_reg : pend_reg + WORD_W'(1);
    assign out_free = !out_valid_reg || out_ready;
    assign push_mid = (cmd.emit || cmd.flush) && held_valid_reg;

    always_comb
    begin
        if ((high_reg & TOP_BIT) == '0)
            dec = DEC_ZERO;
        else if ((low_reg & TOP_BIT) != '0)
            dec = DEC_ONE;
        else if ((low_reg & SECOND_BIT) != '0 && (high_reg & SECOND_BIT) == '0)
            dec = DEC_E3;
        else
            dec = DEC_STOP;
    end

    assign status = '{dec: dec, fin: fin_reg, held_valid: held_valid_reg,
                      out_free: out_free};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= SIZE_RESET;
            low_reg        <= '0;
            high_reg       <= '1;
            pend_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_wdata;

            if (cmd.update)
            begin
                low_reg  <= low_sum;
                high_reg <= low_sum + quo_reg;
            end
            else if (cmd.emit)
            begin
                low_reg  <= low_reg << 1;
                high_reg <= (high_reg << 1) | WORD_W'(1);
            end
            else if (cmd.e3)
            begin
                low_reg  <= (low_reg << 1) & ~TOP_BIT;
                high_reg <= (high_reg << 1) | TOP_BIT | WORD_W'(1);
            end

            if (cmd.emit || cmd.flush)
                pend_reg <= '0;
            else if (cmd.e3)
                pend_reg <= pend_sat;

            if (cmd.emit || cmd.flush)
                held_valid_reg <= 1'b1;
            else if (cmd.final_push)
                held_valid_reg <= 1'b0;

            if (push_mid || cmd.final_push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg <= (sym_ext >= div_eff) ? div_eff - SIZE_W'(1) : sym_ext;
            fin_reg <= in_finish;
            rem_reg <= '0;
            quo_reg <= high_reg - low_reg;
        end
        else if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            rem_reg <= trial_ge ? SIZE_W'(trial - {1'b0, div_eff}) : trial[SIZE_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], trial_ge};
        end

        if (cmd.mul)
            prod_reg <= mul_full[WORD_W-1:0];

        if (cmd.emit)
        begin
            held_bit_reg    <= low_reg[WORD_W-1];
            held_follow_reg <= pend_reg;
        end
        else if (cmd.flush)
        begin
            held_bit_reg    <= low_reg[WORD_W-1] | low_reg[WORD_W-2];
            held_follow_reg <= pend_sat;
        end

        if (push_mid || cmd.final_push)
        begin
            out_lead_reg   <= held_bit_reg;
            out_follow_reg <= held_follow_reg;
            out_last_reg   <= cmd.final_push;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_lead   = out_lead_reg;
    assign out_follow = out_follow_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

// ----- sv/uniform_arith_encoder.sv -----
// a symbol is taken in idle, then runs the bit-serial divider loop, a multiply and the interval update,
// then renormalization steps (up to 32), plus a flush run when finish is set, before returning to idle
// renormalization does one step per cycle, but an output step waits for a free output slot; a new
// symbol is accepted only once the coder is back to idle
// the output register lets the next symbol start while a result waits
// reset: asynchronous, active low; interval full, pending count zero, alphabet size 256
`default_nettype none
module uniform_arith_encoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [uae_pkg::SIZE_W-1:0]     cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [uae_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // symbol
    input  wire logic                           s_axis_tlast,   // finish
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [uae_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // lead_bit, follow_count, zeros
    output logic                                m_axis_tlast    // last
);
    import uae_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              out_lead;
    logic [WORD_W-1:0] out_follow;

    uae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uae_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_symbol  (s_axis_tdata[SYM_W-1:0]),
        .in_finish  (s_axis_tlast),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_lead   (out_lead),
        .out_follow (out_follow),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - WORD_W - 1){1'b0}}, out_follow, out_lead};

endmodule
`default_nettype wire

// ----- sv/uae_checker.sv -----
`default_nettype none
module uae_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [uae_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                          m_axis_tlast
);
    import uae_pkg::*;

    // a symbol occupies the coder for at least the divider loop
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after a transaction");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:WORD_W+1] == '0)
        else $error("output padding bits not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    // the final run of a symbol goes out only once the coder is back to idle
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && !$stable(m_axis_tdata) |-> s_axis_tready)
        else $error("final run shown while coder busy");

endmodule

bind uniform_arith_encoder uae_checker u_uae_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
